### rtl/mish_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mish_pkg
// Shared constants and pipeline payload types for the Mish activation block.
// ----------------------------------------------------------------------------
package mish_pkg;

  // default sample format
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  // widest sample magnitude carried down the pipe
  localparam int MAG_W = 32;

  // range reduction: ln2 in Q56, quotient k below 93
  localparam logic [63:0] LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;
  localparam int          K_W     = 7;

  // 1.0 in Q62
  localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;

  // Taylor series of e^-r
  localparam int EXP_TERMS = 24;

  // divide by the term index: three 21-bit digits, remainder below 32
  localparam int DIGIT_W = 21;
  localparam int REM_W   = 5;
  localparam int V_W     = DIGIT_W + REM_W;
  localparam int RECIP_W = V_W + 1;

  // stage counts of each section
  localparam int RED_STAGES   = 8;
  localparam int TERM_STAGES  = 9;
  localparam int RATIO_STAGES = 67;
  localparam int SCALE_STAGES = 2;
  localparam int PIPE_DEPTH   = RED_STAGES + EXP_TERMS * TERM_STAGES +
                                RATIO_STAGES + SCALE_STAGES;

  // per-sample context that travels with every stage
  typedef struct packed {
    logic             neg;
    logic             last;
    logic             big;
    logic [MAG_W-1:0] mag;
    logic [K_W-1:0]   k;
    logic [61:0]      r62;
  } ctx_t;

  // running state of the exponential series
  typedef struct packed {
    ctx_t        ctx;
    logic [63:0] esum;
    logic [62:0] term;
  } exp_t;

  // tanh(softplus(x)) in Q62
  typedef struct packed {
    ctx_t        ctx;
    logic [62:0] t;
  } ratio_t;

endpackage

`default_nettype wire

### rtl/mish_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mish_if
// Valid/ready channels for samples entering and results leaving the block.
// ----------------------------------------------------------------------------
interface mish_in_if import mish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_value;
  logic                         last_in;

  modport source  (output valid, x_value, last_in, input ready);
  modport sink    (input valid, x_value, last_in, output ready);
  modport monitor (input valid, ready, x_value, last_in);
endinterface

interface mish_out_if import mish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] y_value;
  logic                         last_out;

  modport source  (output valid, y_value, last_out, input ready);
  modport sink    (input valid, y_value, last_out, output ready);
  modport monitor (input valid, ready, y_value, last_out);
endinterface

`default_nettype wire

### rtl/mish_activation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mish_activation
// Mish activation y = x*tanh(ln(1+e^x)) on signed fixed-point samples.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock while the output side does not stall
// and returns one rounded result per sample, in order. The pipeline is made of
// the series for e^-r (24 terms of 9 stages each), the restoring divider for
// the tanh ratio, the 8-stage range reduction and the 2-stage output multiply.
// Every stage has its own valid bit, so a stall at the output only halts
// stages that hold data; while any stage is empty a new sample is still taken.
// The last flag travels with its sample unchanged.
// ----------------------------------------------------------------------------
module mish_activation import mish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mish_in_if.sink    sample,
  mish_out_if.source result
);

  localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

  ctx_t   red_data;
  logic   red_valid;
  logic   red_ready;
  exp_t   chain_data  [EXP_TERMS+1];
  logic   chain_valid [EXP_TERMS+1];
  logic   chain_ready [EXP_TERMS+1];
  ratio_t rat_data;
  logic   rat_valid;
  logic   rat_ready;
  logic [DATA_WIDTH-1:0] y_bits;

  // range reduction
  mish_reduce #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sample.valid),
    .up_ready (sample.ready),
    .up_x     (sample.x_value),
    .up_last  (sample.last_in),
    .dn_valid (red_valid),
    .dn_ready (red_ready),
    .dn_data  (red_data)
  );

  // start the series at term = sum = 1.0
  always_comb begin
    chain_data[0].ctx  = red_data;
    chain_data[0].esum = 64'(ONE_Q62);
    chain_data[0].term = ONE_Q62;
  end
  assign chain_valid[0] = red_valid;
  assign red_ready      = chain_ready[0];

  for (genvar n = 0; n < EXP_TERMS; n++) begin : g_term
    mish_term #(
      .N (n + 1)
    ) u_term (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[n]),
      .up_ready (chain_ready[n]),
      .up_data  (chain_data[n]),
      .dn_valid (chain_valid[n+1]),
      .dn_ready (chain_ready[n+1]),
      .dn_data  (chain_data[n+1])
    );
  end

  // z, z^2 and the tanh ratio
  mish_ratio u_ratio (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[EXP_TERMS]),
    .up_ready (chain_ready[EXP_TERMS]),
    .up_data  (chain_data[EXP_TERMS]),
    .dn_valid (rat_valid),
    .dn_ready (rat_ready),
    .dn_data  (rat_data)
  );

  // final multiply and output register
  mish_scale #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (rat_valid),
    .up_ready (rat_ready),
    .up_data  (rat_data),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .dn_y     (y_bits),
    .dn_last  (result.last_out)
  );

  assign result.y_value = y_bits;

  // track samples in flight between the two transfers
  logic             take_in;
  logic             take_out;
  logic [OCC_W-1:0] occ;

  assign take_in  = sample.valid && sample.ready;
  assign take_out = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (take_in && !take_out) begin
      occ <= occ + 1'b1;
    end else if (!take_in && take_out) begin
      occ <= occ - 1'b1;
    end
  end

  a_occ_max: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(PIPE_DEPTH))
    else $error("more samples in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> !result.valid)
    else $error("result presented with no sample in flight");

  a_room_ready: assert property (@(posedge clk) disable iff (rst)
    (occ < OCC_W'(PIPE_DEPTH)) |-> sample.ready)
    else $error("sample refused while a stage is empty");

endmodule

`default_nettype wire

### rtl/mish_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mish_reduce
// Capture a sample, take its magnitude and split |x| into k*ln2 + r.
// One quotient bit of k is settled per stage.
// ----------------------------------------------------------------------------
module mish_reduce import mish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [DATA_WIDTH-1:0] up_x,
  input  logic                  up_last,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output ctx_t                  dn_data
);

  localparam int NS = RED_STAGES;

  ctx_t dat [NS];
  logic vld [NS];
  logic rdy [NS];

  // sign, magnitude and the Q56 form of |x|
  function automatic ctx_t entry(input logic [DATA_WIDTH-1:0] x, input logic lst);
    ctx_t                  c;
    logic [DATA_WIDTH-1:0] magw;
    c      = '0;
    c.neg  = x[DATA_WIDTH-1];
    magw   = c.neg ? (~x + 1'b1) : x;
    c.last = lst;
    c.mag  = MAG_W'(magw);
    c.big  = (64'(magw) >> FRAC_BITS) >= 64'd64;
    c.r62  = 62'(64'(magw) << (56 - FRAC_BITS));
    return c;
  endfunction

  // one restoring step against ln2 << bit; the last step moves r to Q62
  function automatic ctx_t step(input int unsigned idx, input ctx_t s);
    ctx_t        c;
    logic [63:0] lim;
    int unsigned b;
    c   = s;
    b   = RED_STAGES - 1 - idx;
    lim = LN2_Q56 << b;
    if (64'(c.r62) >= lim) begin
      c.r62  = 62'(64'(c.r62) - lim);
      c.k[b] = 1'b1;
    end
    if (idx == NS - 1) begin
      c.r62 = {c.r62[55:0], 6'd0};
    end
    return c;
  endfunction

  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];
  assign dn_data  = dat[NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic nxt_rdy;
    logic src_v;

    if (i == NS - 1) begin : g_tail
      assign nxt_rdy = dn_ready;
    end else begin : g_body
      assign nxt_rdy = rdy[i+1];
    end

    assign rdy[i] = !vld[i] || nxt_rdy;

    if (i == 0) begin : g_head
      assign src_v = up_valid;
      always_ff @(posedge clk) begin
        if (rdy[i] && src_v) begin
          dat[i] <= entry(up_x, up_last);
        end
      end
    end else begin : g_step
      assign src_v = vld[i-1];
      always_ff @(posedge clk) begin
        if (rdy[i] && src_v) begin
          dat[i] <= step(i, dat[i-1]);
        end
      end
    end

    // advance the valid bit when this stage is free or drains
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_v;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mish_term.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mish_term
// One term of the e^-r series: term = floor(floor(term*r/2^62)/N), then add
// or subtract it. The product is built from 32-bit partial products and the
// divide by N runs one 21-bit digit at a time by reciprocal with correction.
// ----------------------------------------------------------------------------
module mish_term import mish_pkg::*; #(
  parameter int N = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  exp_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output exp_t dn_data
);

  localparam int NS = TERM_STAGES;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << V_W) / N);

  typedef struct packed {
    exp_t             e;
    logic [63:0]      pp00;
    logic [63:0]      pp01;
    logic [63:0]      pp10;
    logic [63:0]      pp11;
    logic [62:0]      m;
    logic [REM_W-1:0] rem;
    logic [V_W-1:0]   v;
    logic [V_W-1:0]   qest;
    logic [62:0]      qacc;
  } tst_t;

  tst_t dat [NS];
  logic vld [NS];
  logic rdy [NS];
  tst_t head;

  function automatic tst_t step(input int unsigned idx, input tst_t s);
    tst_t                       c;
    logic [127:0]               p;
    logic [V_W+RECIP_W-1:0]     prod;
    logic [DIGIT_W-1:0]         dig;
    logic [V_W+REM_W-1:0]       qn;
    logic [V_W-1:0]             r;
    logic [V_W-1:0]             q;
    int unsigned                d;
    c = s;
    p = '0;
    prod = '0;
    dig = '0;
    qn = '0;
    r = '0;
    q = '0;
    d = 0;
    case (idx)
      0: begin
        c.pp00 = 64'(c.e.term[31:0])  * 64'(c.e.ctx.r62[31:0]);
        c.pp01 = 64'(c.e.term[31:0])  * 64'(c.e.ctx.r62[61:32]);
        c.pp10 = 64'(c.e.term[62:32]) * 64'(c.e.ctx.r62[31:0]);
        c.pp11 = 64'(c.e.term[62:32]) * 64'(c.e.ctx.r62[61:32]);
      end
      1: begin
        p = {c.pp11, 64'd0} + {31'd0, ({1'b0, c.pp01} + {1'b0, c.pp10}), 32'd0} +
            {64'd0, c.pp00};
        c.m    = {1'b0, p[123:62]};
        c.rem  = '0;
        c.qacc = '0;
      end
      2, 4, 6: begin
        d      = (idx == 2) ? 2 : ((idx == 4) ? 1 : 0);
        dig    = c.m[d*DIGIT_W +: DIGIT_W];
        c.v    = {c.rem, dig};
        prod   = (V_W+RECIP_W)'(c.v) * (V_W+RECIP_W)'(RECIP);
        c.qest = prod[V_W +: V_W];
      end
      3, 5, 7: begin
        qn = (V_W+REM_W)'(c.qest) * (V_W+REM_W)'(N);
        r  = c.v - qn[V_W-1:0];
        q  = c.qest;
        if (r >= V_W'(N)) begin
          q = q + 1'b1;
          r = r - V_W'(N);
        end
        c.qacc = {c.qacc[62-DIGIT_W:0], q[DIGIT_W-1:0]};
        c.rem  = r[REM_W-1:0];
      end
      8: begin
        c.e.term = c.qacc;
        if ((N % 2) == 1) begin
          c.e.esum = c.e.esum - 64'(c.qacc);
        end else begin
          c.e.esum = c.e.esum + 64'(c.qacc);
        end
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // wrap the incoming series state
  always_comb begin
    head   = '0;
    head.e = up_data;
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];
  assign dn_data  = dat[NS-1].e;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic nxt_rdy;
    logic src_v;
    tst_t src_d;

    if (i == NS - 1) begin : g_tail
      assign nxt_rdy = dn_ready;
    end else begin : g_body
      assign nxt_rdy = rdy[i+1];
    end

    if (i == 0) begin : g_head
      assign src_v = up_valid;
      assign src_d = head;
    end else begin : g_step
      assign src_v = vld[i-1];
      assign src_d = dat[i-1];
    end

    assign rdy[i] = !vld[i] || nxt_rdy;

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) begin
        dat[i] <= step(i, src_d);
      end
    end

    // advance the valid bit when this stage is free or drains
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_v;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mish_ratio.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mish_ratio
// Scale e^-r by 2^-k to get z, square it, form the rational tanh(softplus)
// and divide with one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module mish_ratio import mish_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  exp_t   up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output ratio_t dn_data
);

  localparam int NS = RATIO_STAGES;

  typedef struct packed {
    ctx_t        ctx;
    logic [63:0] esum;
    logic [60:0] z60;
    logic [63:0] pphh;
    logic [63:0] pphl;
    logic [63:0] ppll;
    logic [60:0] zz;
    logic [62:0] num;
    logic [62:0] den;
    logic [63:0] rem;
    logic [62:0] q;
  } rst_t;

  rst_t dat [NS];
  logic vld [NS];
  logic rdy [NS];
  rst_t head;

  function automatic rst_t step(input int unsigned idx, input rst_t s);
    rst_t         c;
    logic [63:0]  z62;
    logic [127:0] p;
    c   = s;
    z62 = '0;
    p   = '0;
    case (idx)
      0: begin
        if (!c.ctx.big && (c.ctx.k < K_W'(63))) begin
          z62 = c.esum >> c.ctx.k[5:0];
        end
        c.z60 = z62[62:2];
      end
      1: begin
        c.pphh = 64'(c.z60[60:30]) * 64'(c.z60[60:30]);
        c.pphl = 64'(c.z60[60:30]) * 64'(c.z60[29:0]);
        c.ppll = 64'(c.z60[29:0])  * 64'(c.z60[29:0]);
      end
      2: begin
        p    = (128'(c.pphh) << 60) + (128'(c.pphl) << 31) + 128'(c.ppll);
        c.zz = p[120:60];
      end
      3: begin
        if (!c.ctx.neg) begin
          c.num = (63'(1) << 60) + {1'b0, c.z60, 1'b0};
          c.den = c.num + {1'b0, c.zz, 1'b0};
        end else begin
          c.num = 63'(c.zz) + {1'b0, c.z60, 1'b0};
          c.den = c.num + (63'(1) << 61);
        end
      end
      4: begin
        c.rem = 64'(c.num);
        c.q   = '0;
        if (c.rem >= 64'(c.den)) begin
          c.rem = c.rem - 64'(c.den);
          c.q   = 63'(1);
        end
      end
      default: begin
        c.rem = {c.rem[62:0], 1'b0};
        c.q   = {c.q[61:0], 1'b0};
        if (c.rem >= 64'(c.den)) begin
          c.rem  = c.rem - 64'(c.den);
          c.q[0] = 1'b1;
        end
      end
    endcase
    return c;
  endfunction

  always_comb begin
    head      = '0;
    head.ctx  = up_data.ctx;
    head.esum = up_data.esum;
  end

  assign up_ready  = rdy[0];
  assign dn_valid  = vld[NS-1];
  assign dn_data.ctx = dat[NS-1].ctx;
  assign dn_data.t   = dat[NS-1].q;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic nxt_rdy;
    logic src_v;
    rst_t src_d;

    if (i == NS - 1) begin : g_tail
      assign nxt_rdy = dn_ready;
    end else begin : g_body
      assign nxt_rdy = rdy[i+1];
    end

    if (i == 0) begin : g_head
      assign src_v = up_valid;
      assign src_d = head;
    end else begin : g_step
      assign src_v = vld[i-1];
      assign src_d = dat[i-1];
    end

    assign rdy[i] = !vld[i] || nxt_rdy;

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) begin
        dat[i] <= step(i, src_d);
      end
    end

    // advance the valid bit when this stage is free or drains
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_v;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mish_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mish_scale
// Multiply |x| by t, round half away from zero and restore the sign.
// The second stage is the output register of the block.
// ----------------------------------------------------------------------------
module mish_scale import mish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  ratio_t                up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [DATA_WIDTH-1:0] dn_y,
  output logic                  dn_last
);

  localparam int NS = SCALE_STAGES;

  typedef struct packed {
    ctx_t             ctx;
    logic [62:0]      t;
    logic [63:0]      pl;
    logic [63:0]      ph;
    logic [MAG_W-1:0] y;
  } sst_t;

  sst_t dat [NS];
  logic vld [NS];
  logic rdy [NS];
  sst_t head;

  function automatic sst_t step(input int unsigned idx, input sst_t s);
    sst_t             c;
    logic [95:0]      p;
    logic [MAG_W-1:0] ymag;
    c    = s;
    p    = '0;
    ymag = '0;
    case (idx)
      0: begin
        c.pl = 64'(c.ctx.mag) * 64'(c.t[31:0]);
        c.ph = 64'(c.ctx.mag) * 64'(c.t[62:32]);
      end
      1: begin
        p    = (96'(c.ph) << 32) + 96'(c.pl) + (96'(1) << 61);
        ymag = p[62 +: MAG_W];
        c.y  = c.ctx.neg ? (~ymag + 1'b1) : ymag;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  always_comb begin
    head     = '0;
    head.ctx = up_data.ctx;
    head.t   = up_data.t;
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];
  assign dn_y     = dat[NS-1].y[DATA_WIDTH-1:0];
  assign dn_last  = dat[NS-1].ctx.last;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic nxt_rdy;
    logic src_v;
    sst_t src_d;

    if (i == NS - 1) begin : g_tail
      assign nxt_rdy = dn_ready;
    end else begin : g_body
      assign nxt_rdy = rdy[i+1];
    end

    if (i == 0) begin : g_head
      assign src_v = up_valid;
      assign src_d = head;
    end else begin : g_step
      assign src_v = vld[i-1];
      assign src_d = dat[i-1];
    end

    assign rdy[i] = !vld[i] || nxt_rdy;

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) begin
        dat[i] <= step(i, src_d);
      end
    end

    // advance the valid bit when this stage is free or drains
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_v;
      end
    end
  end

  // a non-negative sample never gives a negative result
  a_pos_sign: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && !dat[NS-1].ctx.neg) |-> !dn_y[DATA_WIDTH-1])
    else $error("positive sample produced negative result");

  // a negative sample gives zero or a negative result
  a_neg_sign: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && dat[NS-1].ctx.neg) |-> (dn_y[DATA_WIDTH-1] || (dn_y == '0)))
    else $error("negative sample produced positive result");

  // large positive samples pass straight through
  a_big_pos: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && dat[NS-1].ctx.big && !dat[NS-1].ctx.neg) |->
    (dn_y == dat[NS-1].ctx.mag[DATA_WIDTH-1:0]))
    else $error("large positive sample not passed through");

  // large negative samples give zero
  a_big_neg: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && dat[NS-1].ctx.big && dat[NS-1].ctx.neg) |-> (dn_y == '0))
    else $error("large negative sample not zero");

endmodule

`default_nettype wire

### verif/mish_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_checker
// Watches the sample and result channels, predicts each Mish result in fixed
// point and compares it, in order, with what the block returns.
// ----------------------------------------------------------------------------
module mish_checker import mish_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  mish_in_if.monitor      sample,
  mish_out_if.monitor     result,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] y;
    logic                  last;
  } mish_res_t;

  mish_res_t mish_queue[$];

  // floor(a * b / 2^s) at full width
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = a * b;
    return 64'(p >> s);
  endfunction

  // e^-r in Q62 by a truncated Taylor series
  function automatic logic [63:0] exp_neg(logic [63:0] r);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'h4000_0000_0000_0000;
    sum  = term;
    for (int n = 1; n <= EXP_TERMS; n++) begin
      term = mul_shift(term, r, 62) / 64'(n);
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // compute the expected Mish result for one raw sample
  function automatic logic [DATA_WIDTH-1:0] mish_of(logic [DATA_WIDTH-1:0] raw);
    logic        neg;
    logic [63:0] mag, z62, z60, zz, num, den, t, a56, k, r56, ymag;
    logic [127:0] prod, q;
    neg = raw[DATA_WIDTH-1];
    mag = neg ? 64'((~raw + 1'b1) & {DATA_WIDTH{1'b1}}) : 64'(raw);
    if (neg && mag == 0) mag = 64'(1) << (DATA_WIDTH - 1);
    z62 = 0;
    if ((mag >> FRAC_BITS) < 64) begin
      a56 = mag << (56 - FRAC_BITS);
      k   = a56 / LN2_Q56;
      r56 = a56 - k * LN2_Q56;
      z62 = (k >= 63) ? 64'd0 : (exp_neg(r56 << 6) >> k);
    end
    z60 = z62 >> 2;
    zz  = mul_shift(z60, z60, 60);
    if (!neg) begin
      num = (64'(1) << 60) + 2 * z60;
      den = num + 2 * zz;
    end else begin
      num = zz + 2 * z60;
      den = num + (64'(1) << 61);
    end
    q = (128'(num) << 62) / 128'(den);
    t = 64'(q);
    prod = 128'(mag) * 128'(t) + (128'(1) << 61);
    ymag = 64'(prod >> 62);
    return neg ? DATA_WIDTH'(~ymag + 1) : DATA_WIDTH'(ymag);
  endfunction

  assign pending = mish_queue.size();

  // predict on each sample transfer, compare on each result transfer
  always @(posedge clk) begin
    mish_res_t got, exp_r;
    int        errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (sample.valid && sample.ready)
        mish_queue.push_back('{y: mish_of(sample.x_value), last: sample.last_in});
      if (result.valid && result.ready) begin
        if (mish_queue.size() == 0) begin
          $error("unexpected result y_value=%0d", result.y_value);
          errs = errs + 1;
        end else begin
          exp_r = mish_queue.pop_front();
          got   = '{y: result.y_value, last: result.last_out};
          if (got.y !== exp_r.y) begin
            $error("y_value expected %0d actual %0d", $signed(exp_r.y), $signed(got.y));
            errs = errs + 1;
          end
          if (got.last !== exp_r.last) begin
            $error("last_out expected %0b actual %0b", exp_r.last, got.last);
            errs = errs + 1;
          end
        end
      end
      if (errs > 0) begin
        fail_count <= fail_count + errs;
      end
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random samples into the Mish block with random gaps
// and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import mish_pkg::*;

  localparam int DW         = DATA_WIDTH_DEF;
  localparam int N_RANDOM   = 1300;
  localparam int CYCLE_MAX  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;

  mish_in_if  #(.DATA_WIDTH(DW)) sample ();
  mish_out_if #(.DATA_WIDTH(DW)) result ();

  mish_activation #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS_DEF)) DUT (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source)
  );

  mish_checker #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS_DEF)) u_checker (
    .clk(clk), .rst(rst), .sample(sample.monitor), .result(result.monitor),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // pick a gap length: mostly none or short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // random output stalls, with stall-free stretches
  initial begin
    int n;
    result.ready = 1'b0;
    forever begin
      n = gap_len();
      @(posedge clk) result.ready <= (n == 0);
      repeat (n > 0 ? n - 1 : $urandom_range(20)) @(posedge clk);
    end
  end

  // abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_MAX) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // hold valid with a sample until it is taken, then idle for a random gap
  task automatic send_sample(logic [DW-1:0] x, logic last);
    int g;
    sample.valid   <= 1'b1;
    sample.x_value <= x;
    sample.last_in <= last;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      sample.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    logic [DW-1:0] directed[$];
    logic [DW-1:0] x;
    int mode;
    sample.valid   = 1'b0;
    sample.x_value = '0;
    sample.last_in = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes, zero, one LSB, +-1.0, and the large-magnitude corner
    directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                 16'h1000, 16'hF000, 16'h0800, 16'hF800, 16'h4000, 16'hC000,
                 16'h5555, 16'hAAAA, 16'h2000, 16'hE000, 16'h00FF, 16'hFF00};
    foreach (directed[i]) send_sample(directed[i], 1'(i % 2));
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(3);
      case (mode)
        0: x = DW'($urandom);
        1: x = DW'($signed($urandom_range(2 * 4096 * 6)) - 4096 * 6);
        2: x = DW'($signed($urandom_range(512)) - 256);
        default: x = {1'($urandom_range(1)), {(DW - 1){$urandom_range(1) == 1}}};
      endcase
      send_sample(x, $urandom_range(7) == 0);
    end
    sample.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
